// File: rtl/core/tld_pkg.sv
// Shared constants, types and helpers for the terminal line discipline.
package tld_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int LEN_W = $clog2(LINE_DEPTH + 1);

  localparam logic [1:0] CMD_RECV = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_XMIT = 2'd2;

  localparam logic [7:0] CH_INTR = 8'h03;
  localparam logic [7:0] CH_EOF  = 8'h04;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NL   = 8'h0A;

  localparam logic [2:0] TERM_NONE  = 3'd0;
  localparam logic [2:0] TERM_CHAR  = 3'd1;
  localparam logic [2:0] TERM_ERASE = 3'd2;
  localparam logic [2:0] TERM_CRLF  = 3'd3;
  localparam logic [2:0] TERM_INTR  = 3'd4;
  localparam logic [2:0] TERM_BELL  = 3'd5;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_LINE = 2'd1;
  localparam logic [1:0] EV_EOF  = 2'd2;
  localparam logic [1:0] EV_INTR = 2'd3;

  localparam logic [2:0] REG_MAP_CR    = 3'd0;
  localparam logic [2:0] REG_SIGNALS   = 3'd1;
  localparam logic [2:0] REG_CANONICAL = 3'd2;
  localparam logic [2:0] REG_ECHO      = 3'd3;
  localparam logic [2:0] REG_OPOST     = 3'd4;
  localparam logic [2:0] REG_ONLCR     = 3'd5;

  typedef struct packed {
    logic map_cr_to_nl;
    logic signals_enable;
    logic canonical_mode;
    logic echo_enable;
    logic output_postprocess;
    logic output_nl_to_crnl;
  } cfg_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] term_kind;
    logic [7:0] term_char;
    logic [7:0] erase_count;
    logic [1:0] event_res;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       from_store;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [7:0] sat_count(input logic [LEN_W-1:0] n);
    logic [31:0] wide;
    wide = 32'(n);
    return (wide > 32'd255) ? 8'hFF : wide[7:0];
  endfunction

endpackage

// File: rtl/core/tty_line_discipline.sv
// Top level of the terminal line discipline: configuration, pipeline and output register.
// The result of an input transfer is registered in the stage register, then in the output
// register, which holds it while out_stall is high. Throughput: one item per cycle while
// in_stall is low; the line store is read or written at most once per item, and the read
// data is registered before it reaches the output register.
// Reset clears the line length, completion flag, read position and pipeline valids,
// and sets every configuration register to one; the line store itself is not cleared.
module tty_line_discipline (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic [2:0] reg_index,
  input  logic       write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       accepted,
  output logic [2:0] term_kind,
  output logic [7:0] term_char,
  output logic [7:0] erase_count,
  output logic [1:0] event_res,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic       data_last
);
  import tld_pkg::*;

  cfg_t     cfg;
  res_t     res;
  mem_req_t req;
  logic     accept;
  logic     advance;
  logic     s1_load;
  logic     s1_valid;
  res_t     s1_res;
  logic [7:0] rdata;

  assign advance  = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || advance;
  assign in_stall = !s1_load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '1;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_MAP_CR:    cfg.map_cr_to_nl       <= write_data;
        REG_SIGNALS:   cfg.signals_enable     <= write_data;
        REG_CANONICAL: cfg.canonical_mode     <= write_data;
        REG_ECHO:      cfg.echo_enable        <= write_data;
        REG_OPOST:     cfg.output_postprocess <= write_data;
        REG_ONLCR:     cfg.output_nl_to_crnl  <= write_data;
        default: ;
      endcase
    end
  end

  tld_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .byte_in (byte_in),
    .cfg     (cfg),
    .res     (res),
    .req     (req)
  );

  tld_store u_store (
    .clk    (clk),
    .req    (req),
    .enable (accept),
    .rdata  (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= accept;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_res <= res;
    end
    if (advance) begin
      accepted    <= s1_res.accepted;
      term_kind   <= s1_res.term_kind;
      term_char   <= s1_res.term_char;
      erase_count <= s1_res.erase_count;
      event_res   <= s1_res.event_res;
      data_valid  <= s1_res.data_valid;
      data_byte   <= s1_res.from_store ? rdata : s1_res.data_byte;
      data_last   <= s1_res.data_last;
    end
  end

endmodule

// File: rtl/core/tld_store.sv
// Line store memory with one write port and one registered read port.
module tld_store (
  input  logic              clk,
  input  tld_pkg::mem_req_t req,
  input  logic              enable,
  output logic [7:0]        rdata
);
  import tld_pkg::*;

  logic [7:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (enable && req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (enable && req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: rtl/core/tld_ctrl.sv
// Line editing decisions and line control state.
module tld_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        command,
  input  logic [7:0]        byte_in,
  input  tld_pkg::cfg_t     cfg,
  output tld_pkg::res_t     res,
  output tld_pkg::mem_req_t req
);
  import tld_pkg::*;

  logic [LEN_W-1:0] line_length, line_length_next;
  logic             line_complete, line_complete_next;
  logic [LEN_W-1:0] read_position, read_position_next;
  logic [7:0]       c;
  logic             has_room;
  logic [LEN_W-1:0] rp_inc;

  always_comb begin
    res                = '0;
    res.accepted       = 1'b1;
    req                = '0;
    line_length_next   = line_length;
    line_complete_next = line_complete;
    read_position_next = read_position;
    c        = (cfg.map_cr_to_nl && byte_in == CH_CR) ? CH_NL : byte_in;
    has_room = line_length < LEN_W'(LINE_DEPTH);
    rp_inc   = read_position + LEN_W'(1);
    req.waddr = line_length[IDX_W-1:0];
    req.wdata = c;
    req.raddr = read_position[IDX_W-1:0];

    unique case (command)
      CMD_RECV: begin
        if (!cfg.canonical_mode) begin
          if (cfg.signals_enable && c == CH_INTR) begin
            res.event_res = EV_INTR;
          end else begin
            if (cfg.echo_enable) begin
              if (c == CH_NL && cfg.output_postprocess && cfg.output_nl_to_crnl) begin
                res.term_kind = TERM_CRLF;
              end else begin
                res.term_kind = TERM_CHAR;
                res.term_char = c;
              end
            end
            res.data_valid = 1'b1;
            res.data_byte  = c;
            res.data_last  = 1'b1;
          end
        end else if (line_complete) begin
          res.accepted = 1'b0;
        end else if (cfg.signals_enable && c == CH_INTR) begin
          line_length_next   = '0;
          line_complete_next = 1'b0;
          read_position_next = '0;
          res.term_kind      = cfg.echo_enable ? TERM_INTR : TERM_NONE;
          res.event_res      = EV_INTR;
        end else if (c == CH_BS || c == CH_DEL) begin
          if (line_length != '0) begin
            line_length_next = line_length - LEN_W'(1);
            if (cfg.echo_enable) begin
              res.term_kind   = TERM_ERASE;
              res.erase_count = 8'd1;
            end
          end
        end else if (c == CH_KILL) begin
          line_length_next = '0;
          if (cfg.echo_enable && line_length != '0) begin
            res.term_kind   = TERM_ERASE;
            res.erase_count = sat_count(line_length);
          end
        end else if (c == CH_EOF) begin
          if (line_length == '0) begin
            res.event_res = EV_EOF;
          end else begin
            line_complete_next = 1'b1;
            read_position_next = '0;
            res.event_res      = EV_LINE;
          end
        end else if (c == CH_NL) begin
          if (has_room) begin
            req.we           = 1'b1;
            line_length_next = line_length + LEN_W'(1);
          end
          if (cfg.echo_enable) begin
            res.term_kind = TERM_CRLF;
          end
          line_complete_next = 1'b1;
          read_position_next = '0;
          res.event_res      = EV_LINE;
        end else if (has_room) begin
          req.we           = 1'b1;
          line_length_next = line_length + LEN_W'(1);
          if (cfg.echo_enable) begin
            res.term_kind = TERM_CHAR;
            res.term_char = c;
          end
        end else begin
          res.term_kind = TERM_BELL;
        end
      end
      CMD_READ: begin
        if (line_complete) begin
          if (read_position >= line_length) begin
            line_length_next   = '0;
            line_complete_next = 1'b0;
            read_position_next = '0;
          end else begin
            req.re             = 1'b1;
            res.data_valid     = 1'b1;
            res.from_store     = 1'b1;
            read_position_next = rp_inc;
            if (rp_inc >= line_length) begin
              res.data_last      = 1'b1;
              line_length_next   = '0;
              line_complete_next = 1'b0;
              read_position_next = '0;
            end
          end
        end
      end
      CMD_XMIT: begin
        if (cfg.output_postprocess && cfg.output_nl_to_crnl && byte_in == CH_NL) begin
          res.term_kind = TERM_CRLF;
        end else begin
          res.term_kind = TERM_CHAR;
          res.term_char = byte_in;
        end
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      line_complete <= 1'b0;
      read_position <= '0;
    end else if (accept) begin
      line_length   <= line_length_next;
      line_complete <= line_complete_next;
      read_position <= read_position_next;
    end
  end

endmodule

// File: bench/tld_checker.sv
// Checker for the terminal line discipline: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module tld_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic [2:0] reg_index,
  input  logic       write_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] byte_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       accepted,
  input  logic [2:0] term_kind,
  input  logic [7:0] term_char,
  input  logic [7:0] erase_count,
  input  logic [1:0] event_res,
  input  logic       data_valid,
  input  logic [7:0] data_byte,
  input  logic       data_last,
  output int         errors,
  output int         pending
);
  import tld_pkg::*;

  typedef struct packed {
    logic       accepted;
    logic [2:0] term_kind;
    logic [7:0] term_char;
    logic [7:0] erase_count;
    logic [1:0] event_res;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
  } line_out_t;

  line_out_t  pending_replies[$];
  cfg_t       flags;
  logic [7:0] line_chars [LINE_DEPTH];
  int         line_len;
  int         rd_pos;
  logic       line_done;

  function automatic void release_line();
    line_len  = 0;
    rd_pos    = 0;
    line_done = 1'b0;
  endfunction

  function automatic line_out_t discipline_step(input logic [1:0] cmd,
                                                input logic [7:0] raw_char);
    line_out_t  r;
    logic [7:0] c;
    r = '0;
    r.accepted = 1'b1;
    c = raw_char;
    case (cmd)
      CMD_RECV: begin
        if (flags.map_cr_to_nl && c == CH_CR) c = CH_NL;
        if (!flags.canonical_mode) begin
          if (flags.signals_enable && c == CH_INTR) begin
            r.event_res = EV_INTR;
          end else begin
            if (flags.echo_enable) begin
              if (c == CH_NL && flags.output_postprocess && flags.output_nl_to_crnl) begin
                r.term_kind = TERM_CRLF;
              end else begin
                r.term_kind = TERM_CHAR;
                r.term_char = c;
              end
            end
            r.data_valid = 1'b1;
            r.data_byte  = c;
            r.data_last  = 1'b1;
          end
        end else if (line_done) begin
          r.accepted = 1'b0;
        end else if (flags.signals_enable && c == CH_INTR) begin
          release_line();
          r.term_kind = flags.echo_enable ? TERM_INTR : TERM_NONE;
          r.event_res = EV_INTR;
        end else if (c == CH_BS || c == CH_DEL) begin
          if (line_len > 0) begin
            line_len--;
            if (flags.echo_enable) begin
              r.term_kind   = TERM_ERASE;
              r.erase_count = 8'd1;
            end
          end
        end else if (c == CH_KILL) begin
          if (flags.echo_enable && line_len > 0) begin
            r.term_kind   = TERM_ERASE;
            r.erase_count = (line_len > 255) ? 8'hFF : 8'(line_len);
          end
          line_len = 0;
        end else if (c == CH_EOF) begin
          if (line_len == 0) begin
            r.event_res = EV_EOF;
          end else begin
            line_done   = 1'b1;
            rd_pos      = 0;
            r.event_res = EV_LINE;
          end
        end else if (c == CH_NL) begin
          if (line_len < LINE_DEPTH) begin
            line_chars[line_len] = c;
            line_len++;
          end
          if (flags.echo_enable) r.term_kind = TERM_CRLF;
          line_done   = 1'b1;
          rd_pos      = 0;
          r.event_res = EV_LINE;
        end else if (line_len < LINE_DEPTH) begin
          line_chars[line_len] = c;
          line_len++;
          if (flags.echo_enable) begin
            r.term_kind = TERM_CHAR;
            r.term_char = c;
          end
        end else begin
          r.term_kind = TERM_BELL;
        end
      end
      CMD_READ: begin
        if (line_done) begin
          if (rd_pos >= line_len) begin
            release_line();
          end else begin
            r.data_valid = 1'b1;
            r.data_byte  = line_chars[rd_pos];
            rd_pos++;
            if (rd_pos >= line_len) begin
              r.data_last = 1'b1;
              release_line();
            end
          end
        end
      end
      CMD_XMIT: begin
        if (flags.output_postprocess && flags.output_nl_to_crnl && c == CH_NL) begin
          r.term_kind = TERM_CRLF;
        end else begin
          r.term_kind = TERM_CHAR;
          r.term_char = c;
        end
      end
      default: r.accepted = 1'b0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    line_out_t got;
    line_out_t want;
    if (rst) begin
      flags = '1;
      errors = 0;
      release_line();
      pending_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {accepted, term_kind, term_char, erase_count, event_res,
               data_valid, data_byte, data_last};
        if (pending_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch, expected acc=%0d kind=%0d char=%02h erase=%0d",
                       $time, want.accepted, want.term_kind, want.term_char,
                       want.erase_count);
              $display("    ev=%0d dv=%0d byte=%02h last=%0d", want.event_res,
                       want.data_valid, want.data_byte, want.data_last);
              $display("  actual acc=%0d kind=%0d char=%02h erase=%0d", got.accepted,
                       got.term_kind, got.term_char, got.erase_count);
              $display("    ev=%0d dv=%0d byte=%02h last=%0d", got.event_res,
                       got.data_valid, got.data_byte, got.data_last);
            end
          end
        end
      end
      if (write_enable) begin
        case (reg_index)
          REG_MAP_CR:    flags.map_cr_to_nl       = write_data;
          REG_SIGNALS:   flags.signals_enable     = write_data;
          REG_CANONICAL: flags.canonical_mode     = write_data;
          REG_ECHO:      flags.echo_enable        = write_data;
          REG_OPOST:     flags.output_postprocess = write_data;
          REG_ONLCR:     flags.output_nl_to_crnl  = write_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_replies.push_back(discipline_step(command, byte_in));
    end
    pending = pending_replies.size();
  end

endmodule

// File: bench/tb_tty_line_discipline.sv
// Testbench top for the terminal line discipline: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_tty_line_discipline;
  import tld_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       write_enable = 1'b0;
  logic [2:0] reg_index = REG_MAP_CR;
  logic       write_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_RECV;
  logic [7:0] byte_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       accepted;
  logic [2:0] term_kind;
  logic [7:0] term_char;
  logic [7:0] erase_count;
  logic [1:0] event_res;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       data_last;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;

  tty_line_discipline DUT (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
    .term_kind(term_kind), .term_char(term_char), .erase_count(erase_count),
    .event_res(event_res), .data_valid(data_valid), .data_byte(data_byte),
    .data_last(data_last)
  );

  tld_checker u_checker (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
    .term_kind(term_kind), .term_char(term_char), .erase_count(erase_count),
    .event_res(event_res), .data_valid(data_valid), .data_byte(data_byte),
    .data_last(data_last), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    byte_in  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index    <= REG_MAP_CR;
    write_data   <= s.map_cr_to_nl;
    @(negedge clk);
    reg_index    <= REG_SIGNALS;
    write_data   <= s.signals_enable;
    @(negedge clk);
    reg_index    <= REG_CANONICAL;
    write_data   <= s.canonical_mode;
    @(negedge clk);
    reg_index    <= REG_ECHO;
    write_data   <= s.echo_enable;
    @(negedge clk);
    reg_index    <= REG_OPOST;
    write_data   <= s.output_postprocess;
    @(negedge clk);
    reg_index    <= REG_ONLCR;
    write_data   <= s.output_nl_to_crnl;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  function automatic logic [7:0] control_char();
    case ($urandom_range(6))
      0:       return CH_INTR;
      1:       return CH_EOF;
      2:       return CH_KILL;
      3:       return CH_BS;
      4:       return CH_DEL;
      5:       return CH_CR;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] any_char();
    return ($urandom_range(99) < 30) ? control_char() : 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] line_char();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 86) return CH_BS;
    if (r < 90) return CH_DEL;
    if (r < 93) return CH_KILL;
    if (r < 95) return CH_INTR;
    return 8'($urandom_range(255));
  endfunction

  task automatic type_line(input int len);
    int r;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(CMD_XMIT, any_char());
      send_item(CMD_RECV, line_char());
    end
    r = $urandom_range(99);
    send_item(CMD_RECV, (r < 60) ? CH_NL : (r < 80) ? CH_CR : CH_EOF);
  endtask

  task automatic read_line(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_item(CMD_RECV, any_char());
      send_item(CMD_READ, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int phase);
    cfg_t       s;
    logic [5:0] bits;
    int         stop_at;
    int         len;
    bits = 6'($urandom_range(63));
    s = bits;
    case (phase)
      0:       s = '1;
      2:       s = '0;
      1, 3, 5, 7: s.canonical_mode = 1'b1;
      4:       s.canonical_mode = 1'b0;
      default: ;
    endcase
    if (phase == 5) s.echo_enable = 1'b0;
    load_settings(s);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 87; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 87; end
      default: begin idle_pct = 6; stall_pct = 6; end
    endcase
    stop_at = n_sent + 190;
    if (phase == 0) begin
      type_line(130);
      read_line(132);
    end
    while (n_sent < stop_at) begin
      if (s.canonical_mode && $urandom_range(99) < 75) begin
        len = ($urandom_range(14) == 0) ? $urandom_range(100, 135) : $urandom_range(12);
        type_line(len);
        read_line(len + 2);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(19))
            0, 1, 2, 3:   send_item(CMD_READ, 8'($urandom_range(255)));
            4, 5, 6:      send_item(CMD_XMIT, any_char());
            7:            send_item(CMD_UNKNOWN, 8'($urandom_range(255)));
            default:      send_item(CMD_RECV, any_char());
          endcase
        end
      end
    end
    if (s.canonical_mode) type_line($urandom_range(1, 5));
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(CMD_RECV, 8'h61);
    send_item(CMD_RECV, CH_BS);
    send_item(CMD_RECV, CH_DEL);
    send_item(CMD_RECV, CH_KILL);
    send_item(CMD_RECV, 8'h00);
    send_item(CMD_RECV, 8'hFF);
    send_item(CMD_RECV, CH_KILL);
    send_item(CMD_RECV, CH_EOF);
    send_item(CMD_RECV, 8'h78);
    send_item(CMD_RECV, CH_CR);
    send_item(CMD_RECV, 8'h79);
    send_item(CMD_RECV, CH_INTR);
    send_item(CMD_READ, 8'hFF);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_XMIT, CH_NL);
    send_item(CMD_XMIT, 8'hFF);
    send_item(CMD_UNKNOWN, 8'hFF);
    send_item(CMD_RECV, 8'h7A);
    send_item(CMD_RECV, CH_EOF);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_RECV, CH_INTR);
    drain();

    for (int p = 0; p < 8; p++) run_phase(p);

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: tty_line_discipline.f
rtl/core/tld_pkg.sv
rtl/core/tld_store.sv
rtl/core/tld_ctrl.sv
rtl/core/tty_line_discipline.sv
bench/tld_checker.sv
bench/tb_tty_line_discipline.sv
